// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Sizes, request codes and word types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 32;
   localparam int CAP_BITS  = 5;
   localparam int AGE_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2
   } req_kind_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] data;
   } req_word_type;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] read_data;
      logic                 evicted;
   } rsp_word_type;

   typedef struct packed {
      logic [ENTRIES-1:0]  valid_vec;
      logic [CNT_BITS-1:0] occupancy;
   } store_status_type;

endpackage

// ----- rtl/lkvc_store.sv -----
// ----------------------------------------------------------------------------
// lkvc_store
// Entry file with parallel key match, LRU age update, evict and insert.
// ----------------------------------------------------------------------------
module lkvc_store import lkvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  req_word_type          req,
   input  logic [CAP_BITS-1:0]   capacity_limit,
   output rsp_word_type          rsp,
   output store_status_type      status
);

   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [AGE_BITS-1:0]  age_ff [ENTRIES];
   logic [AGE_BITS-1:0]  age_in [ENTRIES];
   logic [KEY_BITS-1:0]  key_ff [ENTRIES];
   logic [DATA_BITS-1:0] data_ff [ENTRIES];
   logic [CNT_BITS-1:0]  occ_ff, occ_in;

   logic [ENTRIES-1:0]   match, evict_oh, valid_kept, free_vec, ins_oh;
   logic                 hit;
   logic [AGE_BITS-1:0]  hit_age;
   logic [DATA_BITS-1:0] hit_data;
   logic [CMP_BITS-1:0]  cap_ext, cap_eff;
   logic [CNT_BITS-1:0]  occ_m1;
   logic                 full, need_evict;
   logic                 do_lookup, do_add_hit, do_add_new, do_remove;

   // keys are unique among valid entries, so at most one match
   always_comb begin
      hit_age  = '0;
      hit_data = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (match[i]) begin
            hit_age  = hit_age | age_ff[i];
            hit_data = hit_data | data_ff[i];
         end
      end
      hit = |match;
   end

   always_comb begin
      do_lookup  = 1'b0;
      do_add_hit = 1'b0;
      do_add_new = 1'b0;
      do_remove  = 1'b0;
      unique case (req.kind)
         REQ_LOOKUP: begin
            do_lookup = hit;
         end
         REQ_ADD: begin
            do_add_hit = hit;
            do_add_new = !hit;
         end
         REQ_REMOVE: begin
            do_remove = hit;
         end
         default: begin
         end
      endcase
   end

   // capacity clamped to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_BITS'(capacity_limit);
      if (cap_ext == '0) begin
         cap_eff = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
         cap_eff = CMP_BITS'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      full       = CMP_BITS'(occ_ff) >= cap_eff;
      need_evict = do_add_new && full;
   end

   // oldest valid entry carries age occupancy-1
   always_comb begin
      occ_m1 = occ_ff - CNT_BITS'(1);
      for (int i = 0; i < ENTRIES; i++) begin
         evict_oh[i] = need_evict && valid_ff[i] && (age_ff[i] == occ_m1[AGE_BITS-1:0]);
      end
      valid_kept = valid_ff & ~evict_oh;
      free_vec   = ~valid_kept;
      ins_oh     = do_add_new ? (free_vec & (~free_vec + ENTRIES'(1))) : '0;
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (do_lookup || do_add_hit) begin
            if (match[i]) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
               age_in[i] = age_ff[i] + AGE_BITS'(1);
            end
         end else if (do_add_new) begin
            if (ins_oh[i]) begin
               valid_in[i] = 1'b1;
               age_in[i]   = '0;
            end else if (evict_oh[i]) begin
               valid_in[i] = 1'b0;
               age_in[i]   = '0;
            end else if (valid_ff[i]) begin
               age_in[i] = age_ff[i] + AGE_BITS'(1);
            end
         end else if (do_remove) begin
            if (match[i]) begin
               valid_in[i] = 1'b0;
               age_in[i]   = '0;
            end else if (valid_ff[i] && (age_ff[i] > hit_age)) begin
               age_in[i] = age_ff[i] - AGE_BITS'(1);
            end
         end
      end
      if (do_add_new) begin
         occ_in = need_evict ? occ_ff : occ_ff + CNT_BITS'(1);
      end else if (do_remove) begin
         occ_in = occ_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (fire) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (ins_oh[i]) begin
               key_ff[i]  <= req.key;
               data_ff[i] <= req.data;
            end else if (do_add_hit && match[i]) begin
               data_ff[i] <= req.data;
            end
         end
      end
   end

   assign rsp.hit       = do_lookup || do_add_hit || do_remove;
   assign rsp.read_data = do_lookup ? hit_data : '0;
   assign rsp.evicted   = need_evict;

   assign status.valid_vec = valid_ff;
   assign status.occupancy = occ_ff;

endmodule

// ----- rtl/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  dir  handshake                 word
//   req      in   req_valid / req_stall     req_type, req_lookup_key,
//                                           req_write_data
//   rsp      out  rsp_valid / rsp_stall     rsp_hit, rsp_read_data, rsp_evicted
//   csr      in   csr_wr_en                 csr_wr_data (capacity limit)
//
// One request per clock while req_stall is low. A word waits in the input register,
// where the key match, age update and evict/insert over all entries resolve, and is
// captured by the result register once that register is free; rsp_valid rises
// with that capture.
// Reset (synchronous) empties the cache and sets the capacity limit to 16.
// rsp_stall holds the result register; req_stall rises only when the input
// register is full and the result register is held by rsp_stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_value_cache_top import lkvc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic [KEY_BITS-1:0]  req_lookup_key,
   input  logic [DATA_BITS-1:0] req_write_data,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [DATA_BITS-1:0] rsp_read_data,
   output logic                 rsp_evicted,

   input  logic                 csr_wr_en,
   input  logic [CAP_BITS-1:0]  csr_wr_data
);

   logic                s1_valid_ff, s1_valid_in;
   req_word_type        s1_req_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff;
   rsp_word_type        store_rsp;
   store_status_type    store_status;
   logic [CAP_BITS-1:0] cap_ff;

   logic out_free, advance, req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff.kind <= req_kind_type'(req_type);
         s1_req_ff.key  <= req_lookup_key;
         s1_req_ff.data <= req_write_data;
      end
      if (advance) begin
         rsp_word_ff <= store_rsp;
      end
   end

   lkvc_store u_store (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .req            (s1_req_ff),
      .capacity_limit (cap_ff),
      .rsp            (store_rsp),
      .status         (store_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_word_ff.hit;
   assign rsp_read_data = rsp_word_ff.read_data;
   assign rsp_evicted   = rsp_word_ff.evicted;

   `ASSERT_ALWAYS(a_occ_matches_valid, $countones(store_status.valid_vec) == int'(store_status.occupancy), "occupancy out of step with valid entries")
   `ASSERT_ALWAYS(a_occ_bound, store_status.occupancy <= CNT_BITS'(ENTRIES), "occupancy above entry count")
   `ASSERT_NEXT(a_stage_held, s1_valid_ff && !advance, s1_valid_ff, "waiting request dropped")
   `ASSERT_IMPLY(a_evict_only_on_miss, rsp_valid_ff, !(rsp_hit && rsp_evicted), "eviction on a hit")

endmodule
